@@ sv/bde_pkg.sv @@
// Shared widths, field layout, reset defaults and the digit control type of the entry controller.
package bde_pkg;

    localparam int BTN_W   = 6;
    localparam int PH_W    = 13;
    localparam int FREQ_W  = 30;
    localparam int WAVE_W  = 2;
    localparam int CUR_W   = 4;
    localparam int DIG_W   = 4;
    localparam int OUT_W   = 56;

    localparam logic [PH_W-1:0] THR_RESET    = 13'd50;
    localparam int              DEFAULT_FREQ = 10000;

    // Button bits of the event set; the phase event sits above them.
    localparam int EV_LOAD  = 0;
    localparam int EV_LEFT  = 1;
    localparam int EV_RIGHT = 2;
    localparam int EV_UP    = 3;
    localparam int EV_DOWN  = 4;
    localparam int EV_WAVE  = 5;
    localparam int EV_PHASE = 6;
    localparam int EV_W     = 7;

    localparam logic [DIG_W-1:0] DIG_NINE = 4'd9;

    typedef struct packed {
        logic             we;
        logic [DIG_W-1:0] wdata;
    } t_dig_ctrl;

    // Decimal digit of the power-up frequency at a given position.
    function automatic logic [DIG_W-1:0] default_digit(input int pos);
        int f;
        f = DEFAULT_FREQ;
        for (int j = 0; j < pos; j++) begin
            f = f / 10;
        end
        return DIG_W'(f % 10);
    endfunction

endpackage

@@ sv/bcd_digit_entry_controller.sv @@
// Top level of the front-panel digit entry controller with output register.
// Phase-only, load, cursor, waveform and error words go from the event check straight to
// digit-serial binary conversion; up first takes up to DIGITS carry steps, down first up
// to 2*DIGITS scan and borrow steps, all through the single digit store port.
// Throughput: one word at a time; the next word is taken once the sequencer is idle.
// Reset (synchronous, active low) restores the default frequency digits, cursor 0,
// phase 0, waveform 0, threshold 50, and empties the output register.
module bcd_digit_entry_controller #(
    parameter int DIGITS    = 9,
    parameter int ADC_BITS  = 12,
    parameter int MAX_PHASE = 6283,
    localparam int IN_W     = ((bde_pkg::BTN_W + ADC_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [bde_pkg::PH_W-1:0]   i_cfg_wdata,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: button_mask, adc_sample, zero fill
    input  logic [IN_W-1:0]            i_s_tdata,
    // tuser: adc_valid
    input  logic                       i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // tdata: load_strobe, freq_value, phase_mrad, waveform, cursor, zero fill
    output logic [bde_pkg::OUT_W-1:0]  o_m_tdata,
    // tuser: status
    output logic                       o_m_tuser
);
    import bde_pkg::*;

    localparam int PTR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int PAY_W = 1 + FREQ_W + PH_W + WAVE_W + CUR_W;

    logic              w_accept;
    logic              w_idle, w_cmp, w_done, w_out_free;
    logic              w_beat;
    logic [PH_W-1:0]   w_np;
    logic [EV_W-1:0]   w_events;
    logic [PTR_W-1:0]  w_ptr;
    t_dig_ctrl         w_ctrl;
    logic [DIG_W-1:0]  w_rdata;
    logic [CUR_W-1:0]  w_cursor;
    logic [WAVE_W-1:0] w_wave;
    logic              w_status, w_strobe;
    logic [FREQ_W-1:0] w_freq;

    logic [PH_W-1:0]   r_thr;
    logic [PH_W-1:0]   r_phase;
    logic [BTN_W-1:0]  r_btn;
    logic              r_adc_valid;
    logic              r_out_valid;
    logic [PAY_W-1:0]  r_out_data;
    logic              r_out_status;

    assign w_accept   = i_s_tvalid && w_idle;
    assign o_s_tready = w_idle;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_events   = {r_adc_valid && w_beat, r_btn};

    bde_phase_unit #(
        .ADC_BITS  (ADC_BITS),
        .MAX_PHASE (MAX_PHASE)
    ) u_phase (
        .i_clk    (i_clk),
        .i_load   (w_accept),
        .i_sample (i_s_tdata[BTN_W +: ADC_BITS]),
        .i_phase  (r_phase),
        .i_thr    (r_thr),
        .o_np     (w_np),
        .o_beat   (w_beat)
    );

    bde_digit_store #(
        .DIGITS (DIGITS),
        .PTR_W  (PTR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ptr   (w_ptr),
        .i_ctrl  (w_ctrl),
        .o_rdata (w_rdata)
    );

    bde_sequencer #(
        .DIGITS (DIGITS),
        .PTR_W  (PTR_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_events   (w_events),
        .i_rdata    (w_rdata),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_cmp      (w_cmp),
        .o_done     (w_done),
        .o_ptr      (w_ptr),
        .o_ctrl     (w_ctrl),
        .o_cursor   (w_cursor),
        .o_wave     (w_wave),
        .o_status   (w_status),
        .o_strobe   (w_strobe),
        .o_freq     (w_freq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_thr <= i_cfg_wdata;
            end
            // A phase change beyond the threshold is kept even on an error word.
            if (w_cmp && r_adc_valid && w_beat) begin
                r_phase <= w_np;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_btn       <= i_s_tdata[BTN_W-1:0];
            r_adc_valid <= i_s_tuser;
        end
        if (w_done) begin
            r_out_status <= w_status;
            r_out_data   <= {w_cursor, w_wave, r_phase, w_freq, w_strobe};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {(OUT_W - PAY_W)'(0), r_out_data};

endmodule

@@ sv/bde_phase_unit.sv @@
// Sample-to-milliradian scaler and threshold comparator for the phase input.
module bde_phase_unit #(
    parameter int ADC_BITS  = 12,
    parameter int MAX_PHASE = 6283
) (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [ADC_BITS-1:0]       i_sample,
    input  logic [bde_pkg::PH_W-1:0]  i_phase,
    input  logic [bde_pkg::PH_W-1:0]  i_thr,
    output logic [bde_pkg::PH_W-1:0]  o_np,
    output logic                      o_beat
);
    import bde_pkg::*;

    localparam int PROD_W = ADC_BITS + PH_W;

    logic [PROD_W-1:0] w_prod;
    logic [PH_W-1:0]   r_np;
    logic [PH_W-1:0]   w_diff;

    assign w_prod = PROD_W'(i_sample) * PROD_W'(MAX_PHASE);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_np <= w_prod[ADC_BITS +: PH_W];
        end
    end

    assign w_diff = (r_np > i_phase) ? (r_np - i_phase) : (i_phase - r_np);
    assign o_beat = w_diff > i_thr;
    assign o_np   = r_np;

endmodule

@@ sv/bde_digit_store.sv @@
// Decimal digit register file with one walking read/write pointer.
module bde_digit_store #(
    parameter int DIGITS = 9,
    parameter int PTR_W  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [PTR_W-1:0]           i_ptr,
    input  bde_pkg::t_dig_ctrl         i_ctrl,
    output logic [bde_pkg::DIG_W-1:0]  o_rdata
);
    import bde_pkg::*;

    logic [DIG_W-1:0] r_dig [DIGITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_dig[i] <= default_digit(i);
            end
        end else if (i_ctrl.we) begin
            r_dig[i_ptr] <= i_ctrl.wdata;
        end
    end

    assign o_rdata = r_dig[i_ptr];

endmodule

@@ sv/bde_sequencer.sv @@
// Step sequencer that walks the digits for carry, borrow and binary conversion.
module bde_sequencer #(
    parameter int DIGITS = 9,
    parameter int PTR_W  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bde_pkg::EV_W-1:0]   i_events,
    input  logic [bde_pkg::DIG_W-1:0]  i_rdata,
    input  logic                       i_out_free,
    output logic                       o_idle,
    output logic                       o_cmp,
    output logic                       o_done,
    output logic [PTR_W-1:0]           o_ptr,
    output bde_pkg::t_dig_ctrl         o_ctrl,
    output logic [bde_pkg::CUR_W-1:0]  o_cursor,
    output logic [bde_pkg::WAVE_W-1:0] o_wave,
    output logic                       o_status,
    output logic                       o_strobe,
    output logic [bde_pkg::FREQ_W-1:0] o_freq
);
    import bde_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_UP   = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_DOWN = 7'b0010000,
        S_CONV = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam logic [PTR_W-1:0] LAST = PTR_W'(DIGITS - 1);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  r_stop, n_stop;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [WAVE_W-1:0] r_wave, n_wave;
    logic              r_status, n_status;
    logic              r_strobe, n_strobe;
    logic [FREQ_W-1:0] r_acc, n_acc;
    t_dig_ctrl         w_ctrl;
    logic              w_multi;
    logic              w_cur_ok;

    assign w_multi  = (i_events & (i_events - EV_W'(1))) != '0;
    assign w_cur_ok = r_cursor < CUR_W'(DIGITS);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_stop   = r_stop;
        n_cursor = r_cursor;
        n_wave   = r_wave;
        n_status = r_status;
        n_strobe = r_strobe;
        n_acc    = r_acc;
        w_ctrl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_status = 1'b0;
                n_strobe = 1'b0;
                n_acc    = '0;
                n_state  = S_CONV;
                n_ptr    = LAST;
                if (i_events == '0) begin
                    n_state = S_IDLE;
                end else if (w_multi) begin
                    n_status = 1'b1;
                end else begin
                    if (i_events[EV_LOAD]) begin
                        n_strobe = 1'b1;
                    end
                    if (i_events[EV_LEFT]) begin
                        n_cursor = (r_cursor >= CUR_W'(DIGITS - 1)) ? '0
                                                                    : r_cursor + CUR_W'(1);
                    end
                    if (i_events[EV_RIGHT]) begin
                        n_cursor = (r_cursor == '0) ? CUR_W'(DIGITS - 1)
                                                    : r_cursor - CUR_W'(1);
                    end
                    if (i_events[EV_WAVE]) begin
                        n_wave = r_wave + WAVE_W'(1);
                    end
                    // Up and down walk upward from the cursor digit.
                    if ((i_events[EV_UP] || i_events[EV_DOWN]) && w_cur_ok) begin
                        n_ptr   = r_cursor[PTR_W-1:0];
                        n_state = i_events[EV_UP] ? S_UP : S_SCAN;
                    end
                end
            end
            S_UP: begin
                w_ctrl.we = 1'b1;
                if (i_rdata >= DIG_NINE) begin
                    w_ctrl.wdata = '0;
                    if (r_ptr == LAST) begin
                        n_ptr   = LAST;
                        n_state = S_CONV;
                    end else begin
                        n_ptr = r_ptr + PTR_W'(1);
                    end
                end else begin
                    w_ctrl.wdata = i_rdata + DIG_W'(1);
                    n_ptr        = LAST;
                    n_state      = S_CONV;
                end
            end
            S_SCAN: begin
                // Find the lowest nonzero digit at or above the cursor.
                if (i_rdata != '0) begin
                    n_stop  = r_ptr;
                    n_ptr   = r_cursor[PTR_W-1:0];
                    n_state = S_DOWN;
                end else if (r_ptr == LAST) begin
                    n_ptr   = LAST;
                    n_state = S_CONV;
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            S_DOWN: begin
                w_ctrl.we = 1'b1;
                if (r_ptr == r_stop) begin
                    w_ctrl.wdata = i_rdata - DIG_W'(1);
                    n_ptr        = LAST;
                    n_state      = S_CONV;
                end else begin
                    w_ctrl.wdata = DIG_NINE;
                    n_ptr        = r_ptr + PTR_W'(1);
                end
            end
            S_CONV: begin
                // Horner step, most significant digit first; truncation to the
                // field width is exact modulo arithmetic.
                n_acc = (r_acc << 3) + (r_acc << 1) + FREQ_W'(i_rdata);
                if (r_ptr == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr - PTR_W'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_wave   <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_wave   <= n_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_stop   <= n_stop;
        r_status <= n_status;
        r_strobe <= n_strobe;
        r_acc    <= n_acc;
    end

    assign o_idle   = r_state == S_IDLE;
    assign o_cmp    = r_state == S_CMP;
    assign o_done   = (r_state == S_DONE) && i_out_free;
    assign o_ptr    = r_ptr;
    assign o_ctrl   = w_ctrl;
    assign o_cursor = r_cursor;
    assign o_wave   = r_wave;
    assign o_status = r_status;
    assign o_strobe = r_strobe;
    assign o_freq   = r_acc;

endmodule
